// ----- hdl/sxfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sxfr_pkg: shared types and constants of the sync/XOR frame receiver
// Frame layout constants, phase and status codes, front-to-back command item.
// ----------------------------------------------------------------------------
package sxfr_pkg;

  localparam int unsigned PayloadLen = 24;
  localparam int unsigned WordCount  = 6;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = 2;
  localparam int unsigned FifoCntW   = 3;

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] TailByte = 8'hEE;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_CHECK   = 3'd2,
    PH_TAIL    = 3'd3,
    PH_START   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TAIL  = 2'd1,
    ST_BAD_CSUM  = 2'd2,
    ST_BAD_START = 2'd3
  } status_e;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_EMIT  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [IdxW-1:0]   idx;
    logic [7:0]        data;
    status_e           status;
  } cmd_t;

endpackage

// ----- hdl/sxfr_front.sv -----
// ----------------------------------------------------------------------------
// sxfr_front: framing parser
// Accepts one byte per cycle while accept_i is high, tracks sync/payload/checksum/tail/start word and
// issues store and emit commands to the back end.
// ----------------------------------------------------------------------------
module sxfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output logic                push_o,
  output sxfr_pkg::cmd_t      cmd_o
);

  sxfr_pkg::phase_e            phase_q, phase_d;
  logic [1:0]                  sync_q, sync_d;
  logic [sxfr_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [7:0]                  xor_q, xor_d;
  logic [7:0]                  csum_q, csum_d;
  logic                        tail_good_q, tail_good_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sxfr_pkg::PH_HUNT;
      sync_q      <= 2'd0;
      idx_q       <= '0;
      xor_q       <= 8'd0;
      csum_q      <= 8'd0;
      tail_good_q <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      sync_q      <= sync_d;
      idx_q       <= idx_d;
      xor_q       <= xor_d;
      csum_q      <= csum_d;
      tail_good_q <= tail_good_d;
    end
  end

  always_comb begin
    logic       is_sync;
    logic       tg;
    logic [1:0] sync_n;
    phase_d     = phase_q;
    sync_d      = sync_q;
    idx_d       = idx_q;
    xor_d       = xor_q;
    csum_d      = csum_q;
    tail_good_d = tail_good_q;
    push_o      = 1'b0;
    cmd_o.kind   = sxfr_pkg::CMD_STORE;
    cmd_o.idx    = idx_q;
    cmd_o.data   = rx_byte_i;
    cmd_o.status = sxfr_pkg::ST_OK;
    is_sync = (rx_byte_i == sxfr_pkg::SyncByte);
    tg      = tail_good_q & (rx_byte_i == sxfr_pkg::TailByte);
    sync_n  = sync_q + {1'b0, is_sync};

    if (accept_i) begin
      unique case (phase_q)
        sxfr_pkg::PH_PAYLOAD: begin
          push_o = 1'b1;
          xor_d  = xor_q ^ rx_byte_i;
          idx_d  = idx_q + 1'b1;
          if (idx_q == sxfr_pkg::IdxW'(sxfr_pkg::PayloadLen - 1)) begin
            phase_d = sxfr_pkg::PH_CHECK;
          end
        end
        sxfr_pkg::PH_CHECK: begin
          csum_d      = rx_byte_i;
          phase_d     = sxfr_pkg::PH_TAIL;
          idx_d       = '0;
          tail_good_d = 1'b1;
        end
        sxfr_pkg::PH_TAIL: begin
          tail_good_d = tg;
          idx_d       = idx_q + 1'b1;
          if (idx_q != '0) begin
            push_o     = 1'b1;
            cmd_o.kind = sxfr_pkg::CMD_EMIT;
            if (!tg || (xor_q != csum_q)) begin
              cmd_o.status = !tg ? sxfr_pkg::ST_BAD_TAIL : sxfr_pkg::ST_BAD_CSUM;
              phase_d = sxfr_pkg::PH_HUNT;
              sync_d  = 2'd0;
              idx_d   = '0;
            end else begin
              cmd_o.status = sxfr_pkg::ST_OK;
              phase_d = sxfr_pkg::PH_START;
              sync_d  = 2'd0;
              idx_d   = '0;
            end
          end
        end
        sxfr_pkg::PH_START: begin
          sync_d = sync_n;
          idx_d  = idx_q + 1'b1;
          if (idx_q != '0) begin
            if (sync_n == 2'd2) begin
              phase_d     = sxfr_pkg::PH_PAYLOAD;
              idx_d       = '0;
              xor_d       = 8'd0;
              sync_d      = 2'd0;
              tail_good_d = 1'b1;
            end else begin
              push_o       = 1'b1;
              cmd_o.kind   = sxfr_pkg::CMD_EMIT;
              cmd_o.status = sxfr_pkg::ST_BAD_START;
              phase_d = sxfr_pkg::PH_HUNT;
              sync_d  = 2'd0;
              idx_d   = '0;
            end
          end
        end
        default: begin
          // hunting; unused phase codes land here too
          phase_d = sxfr_pkg::PH_HUNT;
          if (is_sync) begin
            if (sync_q != 2'd0) begin
              phase_d     = sxfr_pkg::PH_PAYLOAD;
              idx_d       = '0;
              xor_d       = 8'd0;
              sync_d      = 2'd0;
              tail_good_d = 1'b1;
            end else begin
              sync_d = sync_n;
            end
          end else begin
            sync_d = 2'd0;
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/sxfr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// sxfr_cmd_fifo: command queue
// Short register FIFO between the parser and the result stage.
// ----------------------------------------------------------------------------
module sxfr_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sxfr_pkg::cmd_t     push_cmd_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output sxfr_pkg::cmd_t     head_o
);

  sxfr_pkg::cmd_t                 mem_q [sxfr_pkg::FifoDepth];
  logic [sxfr_pkg::FifoPtrW-1:0]  wptr_q, rptr_q;
  logic [sxfr_pkg::FifoCntW-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == sxfr_pkg::FifoCntW'(sxfr_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

// ----- hdl/sxfr_back.sv -----
// ----------------------------------------------------------------------------
// sxfr_back: payload store and result register
// Executes queued commands: stores payload bytes, loads frame results.
// ----------------------------------------------------------------------------
module sxfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sxfr_pkg::cmd_t     head_i,
  output logic               pop_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [31:0]        word_o [sxfr_pkg::WordCount]
);

  logic [7:0]   store_q [sxfr_pkg::PayloadLen];
  logic         out_valid_q;
  logic [1:0]   status_q;
  logic [31:0]  word_q [sxfr_pkg::WordCount];
  logic [31:0]  word_d [sxfr_pkg::WordCount];
  logic         out_free, do_store, do_emit, frame_ok;

  assign out_free = ~out_valid_q | out_ready_i;
  assign do_store = ~empty_i & (head_i.kind == sxfr_pkg::CMD_STORE);
  assign do_emit  = ~empty_i & (head_i.kind == sxfr_pkg::CMD_EMIT) & out_free;
  assign pop_o    = do_store | do_emit;
  assign frame_ok = (head_i.status == sxfr_pkg::ST_OK);

  // words are zero for any error status
  always_comb begin
    for (int w = 0; w < int'(sxfr_pkg::WordCount); w++) begin
      word_d[w] = frame_ok ? {store_q[4*w], store_q[4*w+1], store_q[4*w+2],
                              store_q[4*w+3]} : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) store_q[head_i.idx] <= head_i.data;
    if (do_emit) begin
      status_q <= head_i.status;
      for (int w = 0; w < int'(sxfr_pkg::WordCount); w++) begin
        word_q[w] <= word_d[w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign word_o      = word_q;

endmodule

// ----- hdl/sync_xor_frame_receiver_core.sv -----
// Timing: a result's emit command is queued when its closing byte is accepted,
//   then loaded into the output register once it is at the queue head and the
//   output register is empty or being taken.
// Throughput: one byte per cycle; a result leaves the output register each
//   cycle it is taken. Input stalls only when the 4-deep command queue fills.
// Reset: rst_ni low returns the parser to sync hunt, empties queue and output.
// ----------------------------------------------------------------------------
// sync_xor_frame_receiver_core: sync-word / XOR-checksum deframer
// Hunts for 0xFF 0xFF, collects 24 payload bytes, an XOR checksum and two
// 0xEE tail bytes, and reports six big-endian payload words or an error.
// ----------------------------------------------------------------------------
module sync_xor_frame_receiver_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte input channel
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   rx_byte_i,
  // result channel
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [31:0]  vel_x_word_o,
  output logic [31:0]  vel_y_word_o,
  output logic [31:0]  vel_turn_word_o,
  output logic [31:0]  pos_x_word_o,
  output logic [31:0]  pos_y_word_o,
  output logic [31:0]  heading_word_o
);

  logic            accept;
  logic            push, pop, full, empty;
  sxfr_pkg::cmd_t  push_cmd, head_cmd;
  logic [31:0]     words [sxfr_pkg::WordCount];

  // Ready only depends on queue space, never on the result side directly:
  // the queue absorbs bursts while a result waits to be taken.
  assign in_ready_o = ~full;
  assign accept     = in_valid_i & in_ready_o;

  // Front: byte parser. Every payload byte becomes a store command, every
  // frame end or bad start word becomes an emit command.
  sxfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Queue between parser and result stage.
  sxfr_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_cmd)
  );

  // Back: payload store and output register. Stores drain one per cycle; an
  // emit waits at the queue head until the output register is free, which
  // keeps later payload writes from overtaking the frame being reported.
  sxfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .word_o      (words)
  );

  assign vel_x_word_o    = words[0];
  assign vel_y_word_o    = words[1];
  assign vel_turn_word_o = words[2];
  assign pos_x_word_o    = words[3];
  assign pos_y_word_o    = words[4];
  assign heading_word_o  = words[5];

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sync_xor_frame_receiver_core
// Feeds byte streams of sync runs, frames and noise with random gaps on both
// sides. A scoreboard class predicts each frame result and checks it.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    sxfr_pkg::status_e                     status;
    logic [sxfr_pkg::WordCount-1:0][31:0]  words;
  } frame_result_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS,
    FILL_LEAD_SYNC
  } payload_fill_e;

  typedef enum int {
    FAULT_NONE,
    FAULT_TAIL_FIRST,
    FAULT_TAIL_SECOND,
    FAULT_TAIL_BOTH,
    FAULT_CSUM,
    FAULT_CSUM_TAIL
  } frame_fault_e;

  typedef enum int {
    START_FIRST_BAD,
    START_SECOND_BAD,
    START_BOTH_BAD
  } start_fault_e;

  // --------------------------------------------------------------------------
  // Scoreboard: byte-level deframer predictor plus in-order result check
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    sxfr_pkg::phase_e          phase;
    logic [1:0]                sync_run;
    logic [sxfr_pkg::IdxW-1:0] pos;
    logic [7:0]                xor_acc;
    logic [7:0]                csum_rx;
    logic [7:0]                payload [sxfr_pkg::PayloadLen];
    logic                      tail_ok;
    frame_result_t             expected_q [$];
    int unsigned               predicted;
    int unsigned               errors;
    string                     word_names [sxfr_pkg::WordCount] = '{"vel_x_word",
                                 "vel_y_word", "vel_turn_word", "pos_x_word",
                                 "pos_y_word", "heading_word"};

    function new();
      phase     = sxfr_pkg::PH_HUNT;
      sync_run  = '0;
      pos       = '0;
      xor_acc   = '0;
      csum_rx   = '0;
      tail_ok   = 1'b1;
      predicted = 0;
      errors    = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void restart_frame();
      phase    = sxfr_pkg::PH_PAYLOAD;
      pos      = '0;
      xor_acc  = '0;
      sync_run = '0;
      tail_ok  = 1'b1;
    endfunction

    function void resume_hunt();
      phase    = sxfr_pkg::PH_HUNT;
      sync_run = '0;
      pos      = '0;
    endfunction

    // error results carry all-zero words
    function void post(sxfr_pkg::status_e st, bit with_words);
      frame_result_t r;
      r.status = st;
      r.words  = '0;
      if (with_words) begin
        for (int w = 0; w < sxfr_pkg::WordCount; w++) begin
          r.words[w] = {payload[4*w], payload[4*w+1], payload[4*w+2], payload[4*w+3]};
        end
      end
      expected_q.push_back(r);
      predicted++;
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        sxfr_pkg::PH_PAYLOAD: begin
          if (pos < sxfr_pkg::PayloadLen) payload[pos] = b;
          xor_acc = xor_acc ^ b;
          pos = pos + 1'b1;
          if (pos >= sxfr_pkg::PayloadLen) phase = sxfr_pkg::PH_CHECK;
        end
        sxfr_pkg::PH_CHECK: begin
          csum_rx = b;
          phase   = sxfr_pkg::PH_TAIL;
          pos     = '0;
          tail_ok = 1'b1;
        end
        sxfr_pkg::PH_TAIL: begin
          if (b != sxfr_pkg::TailByte) tail_ok = 1'b0;
          pos = pos + 1'b1;
          if (pos >= 2) begin
            // bad tail outranks a checksum mismatch
            if (!tail_ok) begin
              post(sxfr_pkg::ST_BAD_TAIL, 1'b0);
              resume_hunt();
            end else if (xor_acc != csum_rx) begin
              post(sxfr_pkg::ST_BAD_CSUM, 1'b0);
              resume_hunt();
            end else begin
              post(sxfr_pkg::ST_OK, 1'b1);
              phase    = sxfr_pkg::PH_START;
              pos      = '0;
              sync_run = '0;
            end
          end
        end
        sxfr_pkg::PH_START: begin
          if (b == sxfr_pkg::SyncByte) sync_run = sync_run + 1'b1;
          pos = pos + 1'b1;
          if (pos >= 2) begin
            if (sync_run == 2'd2) begin
              restart_frame();
            end else begin
              post(sxfr_pkg::ST_BAD_START, 1'b0);
              resume_hunt();
            end
          end
        end
        default: begin
          phase = sxfr_pkg::PH_HUNT;
          if (b == sxfr_pkg::SyncByte) begin
            sync_run = sync_run + 1'b1;
            if (sync_run >= 2'd2) restart_frame();
          end else begin
            sync_run = '0;
          end
        end
      endcase
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time,
                 got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      for (int w = 0; w < sxfr_pkg::WordCount; w++) begin
        if (got.words[w] !== want.words[w]) begin
          $display("%0t: %s expected %08h got %08h", $time, word_names[w],
                   want.words[w], got.words[w]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] vel_x_word_o;
  logic [31:0] vel_y_word_o;
  logic [31:0] vel_turn_word_o;
  logic [31:0] pos_x_word_o;
  logic [31:0] pos_y_word_o;
  logic [31:0] heading_word_o;

  sync_xor_frame_receiver_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .vel_x_word_o   (vel_x_word_o),
    .vel_y_word_o   (vel_y_word_o),
    .vel_turn_word_o(vel_turn_word_o),
    .pos_x_word_o   (pos_x_word_o),
    .pos_y_word_o   (pos_y_word_o),
    .heading_word_o (heading_word_o)
  );

  frame_scoreboard sb = new();

  logic [7:0]  byte_q [$];    // bytes waiting to be sent
  bit          tx_burst;      // sender sends back to back
  bit          rx_burst;      // sink takes results back to back
  bit          hold_req;      // ask the sink for one long hold-off
  int unsigned bytes_sent;
  int unsigned cycle_count;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic logic [7:0] not_tail();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == sxfr_pkg::TailByte);
    return v;
  endfunction

  function automatic logic [7:0] not_sync();
    return 8'($urandom_range(0, 254));
  endfunction

  task automatic push_sync();
    byte_q.push_back(sxfr_pkg::SyncByte);
    byte_q.push_back(sxfr_pkg::SyncByte);
  endtask

  // payload, checksum and tail; faults corrupt checksum and/or tail bytes
  task automatic push_frame(payload_fill_e fill, frame_fault_e fault);
    logic [7:0] v;
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < sxfr_pkg::PayloadLen; i++) begin
      case (fill)
        FILL_ONES:      v = 8'hFF;
        FILL_ZEROS:     v = 8'h00;
        FILL_LEAD_SYNC: v = (i == 0) ? sxfr_pkg::SyncByte : 8'($urandom_range(0, 255));
        default:        v = 8'($urandom_range(0, 255));
      endcase
      byte_q.push_back(v);
      x = x ^ v;
    end
    if (fault == FAULT_CSUM || fault == FAULT_CSUM_TAIL) x = x ^ 8'($urandom_range(1, 255));
    byte_q.push_back(x);
    byte_q.push_back((fault == FAULT_TAIL_FIRST || fault == FAULT_TAIL_BOTH ||
                      fault == FAULT_CSUM_TAIL) ? not_tail() : sxfr_pkg::TailByte);
    byte_q.push_back((fault == FAULT_TAIL_SECOND || fault == FAULT_TAIL_BOTH) ?
                     not_tail() : sxfr_pkg::TailByte);
  endtask

  // start word after a good frame that is not 0xFF 0xFF
  task automatic push_bad_start(start_fault_e kind);
    byte_q.push_back(kind == START_SECOND_BAD ? sxfr_pkg::SyncByte : not_sync());
    byte_q.push_back(kind == START_FIRST_BAD ? sxfr_pkg::SyncByte : not_sync());
  endtask

  // --------------------------------------------------------------------------
  // Driving; each task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_queued();
    logic [7:0] b;
    int gap;
    while (byte_q.size() > 0) begin
      b   = byte_q.pop_front();
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= b;
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_byte(b);
      bytes_sent++;
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // random chain: noise, sync, 1..4 frames linked by start words
  task automatic push_chain(bit all_good);
    int n_frames;
    frame_fault_e fault;
    n_frames = all_good ? 4 : $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) begin
      // plain garbage
      repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // short noise, sometimes a lone sync byte
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 2) == 0) byte_q.push_back(sxfr_pkg::SyncByte);
        byte_q.push_back(not_sync());
      end
    end
    push_sync();
    fault = FAULT_NONE;
    for (int f = 0; f < n_frames; f++) begin
      fault = (all_good || $urandom_range(0, 7) < 5) ? FAULT_NONE :
              frame_fault_e'($urandom_range(1, 5));
      push_frame(($urandom_range(0, 7) == 0) ? payload_fill_e'($urandom_range(1, 3)) :
                 FILL_RANDOM, fault);
      if (fault != FAULT_NONE) break;
      if (f < n_frames - 1) push_sync();
    end
    if (fault == FAULT_NONE) push_bad_start(start_fault_e'($urandom_range(0, 2)));
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random ready gaps, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    frame_result_t got;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.status   = sxfr_pkg::status_e'(status_o);
      got.words[0] = vel_x_word_o;
      got.words[1] = vel_y_word_o;
      got.words[2] = vel_turn_word_o;
      got.words[3] = pos_x_word_o;
      got.words[4] = pos_y_word_o;
      got.words[5] = heading_word_o;
      sb.check_result(got);
      if ($urandom_range(0, 5) == 0) rx_burst = !rx_burst;
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sync_xor_frame_receiver_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    tx_burst   = 1'b0;
    rx_burst   = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: broken sync runs, then frames covering each outcome
    byte_q.push_back(8'h00);
    byte_q.push_back(sxfr_pkg::SyncByte);
    byte_q.push_back(8'h7E);
    byte_q.push_back(sxfr_pkg::SyncByte);
    push_sync();
    push_frame(FILL_ONES, FAULT_NONE);        // payload of all sync bytes
    push_sync();
    push_frame(FILL_ZEROS, FAULT_NONE);       // chained frame, zero checksum
    push_bad_start(START_SECOND_BAD);
    push_sync();
    push_frame(FILL_LEAD_SYNC, FAULT_NONE);   // 0xFF right after sync is data
    push_bad_start(START_FIRST_BAD);
    push_sync();
    push_frame(FILL_RANDOM, FAULT_TAIL_FIRST);
    push_sync();
    push_frame(FILL_RANDOM, FAULT_TAIL_SECOND);
    push_sync();
    push_frame(FILL_RANDOM, FAULT_CSUM);
    push_sync();
    push_frame(FILL_RANDOM, FAULT_CSUM_TAIL); // tail error wins
    push_sync();
    push_frame(FILL_RANDOM, FAULT_TAIL_BOTH);
    push_sync();
    push_frame(FILL_RANDOM, FAULT_NONE);
    push_bad_start(START_BOTH_BAD);
    send_queued();
    wait_drained();

    // back-pressure: sink holds off while good frames stream in back to back
    hold_req = 1'b1;
    tx_burst = 1'b1;
    push_chain(1'b1);
    send_queued();

    // random chains with varying sender pace
    while (bytes_sent < 1400 || sb.predicted < 50) begin
      if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
      push_chain(1'b0);
      send_queued();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sync_xor_frame_receiver_core test passed");
    end else begin
      $display("sync_xor_frame_receiver_core test failed");
    end
    $finish;
  end

endmodule
